FILE: src/bve_pkg.sv
// Shared types, constants and control structs of the bounded vector engine.
`default_nettype none

package bve_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WIDTH_DEFAULT = 32;

  localparam int CMD_W     = 3;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int OUT_IDX_W = 7;
  localparam int MAX_WORD_W = 64;

  localparam logic [OUT_IDX_W-1:0] MATCH_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    IDX_HOLD     = 3'd0,
    IDX_COUNT_M1 = 3'd1,
    IDX_POS      = 3'd2,
    IDX_ZERO     = 3'd3,
    IDX_INC      = 3'd4,
    IDX_DEC      = 3'd5
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_AT_COUNT = 2'd0,
    WR_AT_NEXT  = 2'd1,
    WR_AT_PREV  = 2'd2,
    WR_AT_POS   = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD       = 2'd0,
    CNT_GROW_INC   = 2'd1,
    CNT_DEC_SHRINK = 2'd2,
    CNT_CLEAR      = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic    latch;
    idx_op_t idx_op;
    logic    rd_en;
    logic    we;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    rd_capture;
    logic    match_capture;
    logic    err_set;
    logic    out_load;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic bad;
    logic shift_start;
    logic shift_more;
    logic idx_lt_count;
    logic hit;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/bve_in_if.sv
// Command channel: valid, ready and one command item.
`default_nettype none

interface bve_in_if;
  logic                            valid;
  logic                            ready;
  logic [bve_pkg::CMD_W-1:0]       cmd;
  logic [bve_pkg::POS_W-1:0]       position;
  logic signed [bve_pkg::VAL_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input item_value,
                  output ready);
endinterface

`default_nettype wire

FILE: src/bve_out_if.sv
// Result channel: valid, ready and one result item.
`default_nettype none

interface bve_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bve_pkg::VAL_W-1:0]     read_value;
  logic signed [bve_pkg::OUT_IDX_W-1:0] match_index;
  logic [bve_pkg::OUT_IDX_W-1:0]        item_count;
  logic [bve_pkg::OUT_IDX_W-1:0]        capacity_level;
  logic                                error_flag;

  modport source (output valid, output read_value, output match_index,
                  output item_count, output capacity_level, output error_flag,
                  input ready);
  modport sink   (input valid, input read_value, input match_index,
                  input item_count, input capacity_level, input error_flag,
                  output ready);
endinterface

`default_nettype wire

FILE: src/bve_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bve_ram #(
  parameter int WIDTH = bve_pkg::WIDTH_DEFAULT,
  parameter int DEPTH = bve_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/bve_datapath.sv
// Datapath: latched command, index walker, count and capacity, element store, result.
`default_nettype none

module bve_datapath #(
  parameter int DEPTH = bve_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = bve_pkg::WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [bve_pkg::CMD_W-1:0]           cmd,
  input  wire logic [bve_pkg::POS_W-1:0]           position,
  input  wire logic signed [bve_pkg::VAL_W-1:0]    item_value,
  input  wire bve_pkg::dp_ctl_t                    ctl,
  output bve_pkg::dp_stat_t                        stat,
  output logic signed [bve_pkg::VAL_W-1:0]         read_value,
  output logic signed [bve_pkg::OUT_IDX_W-1:0]     match_index,
  output logic [bve_pkg::OUT_IDX_W-1:0]            item_count,
  output logic [bve_pkg::OUT_IDX_W-1:0]            capacity_level,
  output logic                                     error_flag
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = ((CW > bve_pkg::POS_W) ? CW : bve_pkg::POS_W) + 1;

  bve_pkg::cmd_t                    cmd_q;
  logic [bve_pkg::POS_W-1:0]        pos_q;
  logic [WIDTH-1:0]                 val_q;
  logic [IW-1:0]                    idx;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    cap;
  logic [bve_pkg::VAL_W-1:0]        rd_word;
  logic [bve_pkg::OUT_IDX_W-1:0]    match_q;
  logic                             err_q;

  logic [bve_pkg::MAX_WORD_W-1:0]   val_ext;
  logic [bve_pkg::MAX_WORD_W-1:0]   rd_ext;
  logic [IW-1:0]                    pos_ext;
  logic [IW-1:0]                    count_ext;
  logic [IW-1:0]                    cap_ext;
  logic [IW-1:0]                    idx_p1;
  logic [IW-1:0]                    idx_m1;
  logic [IW-1:0]                    pos_p1;
  logic [CW:0]                      cap2;
  logic [CW-1:0]                    cnt_m1;
  logic                             full;

  logic [AW-1:0]                    waddr;
  logic [WIDTH-1:0]                 wdata;
  logic [WIDTH-1:0]                 ram_rdata;

  assign val_ext   = {{(bve_pkg::MAX_WORD_W - bve_pkg::VAL_W){1'b0}}, item_value};
  assign rd_ext    = bve_pkg::MAX_WORD_W'($signed(ram_rdata));
  assign pos_ext   = IW'(pos_q);
  assign count_ext = IW'(count);
  assign cap_ext   = IW'(cap);
  assign idx_p1    = idx + IW'(1);
  assign idx_m1    = idx - IW'(1);
  assign pos_p1    = pos_ext + IW'(1);
  assign cap2      = {cap, 1'b0};
  assign cnt_m1    = count - CW'(1);
  assign full      = (count_ext == IW'(DEPTH));

  // Status toward the controller
  always_comb begin
    stat.cmd          = cmd_q;
    stat.idx_lt_count = (idx < count_ext);
    stat.hit          = (ram_rdata == val_q);
    stat.bad          = 1'b0;
    stat.shift_start  = 1'b0;
    stat.shift_more   = 1'b0;
    unique case (cmd_q) inside
      bve_pkg::CMD_PUSH: begin
        stat.bad = full;
      end
      bve_pkg::CMD_POP: begin
        stat.bad = (count == '0);
      end
      bve_pkg::CMD_INSERT: begin
        stat.bad         = full || (pos_ext > count_ext);
        stat.shift_start = (count_ext != pos_ext);
        stat.shift_more  = (idx != pos_ext);
      end
      bve_pkg::CMD_REMOVE: begin
        stat.bad         = (pos_ext >= count_ext);
        stat.shift_start = (pos_p1 < count_ext);
        stat.shift_more  = (idx_p1 < count_ext);
      end
      bve_pkg::CMD_GET: begin
        stat.bad = (pos_ext >= count_ext);
      end
      default: begin
        stat.bad = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctl.wr_sel)
      bve_pkg::WR_AT_COUNT: begin
        waddr = count_ext[AW-1:0];
        wdata = val_q;
      end
      bve_pkg::WR_AT_NEXT: begin
        waddr = idx_p1[AW-1:0];
        wdata = ram_rdata;
      end
      bve_pkg::WR_AT_PREV: begin
        waddr = idx_m1[AW-1:0];
        wdata = ram_rdata;
      end
      default: begin
        waddr = pos_ext[AW-1:0];
        wdata = val_q;
      end
    endcase
  end

  bve_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ctl.we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctl.rd_en),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Command latch and per-command working result
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= bve_pkg::cmd_t'(cmd);
      pos_q   <= position;
      val_q   <= val_ext[WIDTH-1:0];
      rd_word <= '0;
      match_q <= bve_pkg::MATCH_NONE;
      err_q   <= 1'b0;
    end else begin
      if (ctl.rd_capture) begin
        rd_word <= rd_ext[bve_pkg::VAL_W-1:0];
      end
      if (ctl.match_capture) begin
        match_q <= idx[bve_pkg::OUT_IDX_W-1:0];
      end
      if (ctl.err_set) begin
        err_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.idx_op)
      bve_pkg::IDX_COUNT_M1: idx <= count_ext - IW'(1);
      bve_pkg::IDX_POS:      idx <= pos_ext;
      bve_pkg::IDX_ZERO:     idx <= '0;
      bve_pkg::IDX_INC:      idx <= idx_p1;
      bve_pkg::IDX_DEC:      idx <= idx_m1;
      default:               idx <= idx;
    endcase
  end

  // Count and logical capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CW'(1);
    end else begin
      case (ctl.cnt_op)
        bve_pkg::CNT_GROW_INC: begin
          if (count == cap) begin
            cap <= (cap2 > (CW + 1)'(DEPTH)) ? CW'(DEPTH) : cap2[CW-1:0];
          end
          count <= count + CW'(1);
        end
        bve_pkg::CNT_DEC_SHRINK: begin
          if (cnt_m1 < (cap >> 1)) begin
            cap <= cap >> 1;
          end
          count <= cnt_m1;
        end
        bve_pkg::CNT_CLEAR: begin
          count <= '0;
          cap   <= CW'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      read_value     <= rd_word;
      match_index    <= match_q;
      item_count     <= count_ext[bve_pkg::OUT_IDX_W-1:0];
      capacity_level <= cap_ext[bve_pkg::OUT_IDX_W-1:0];
      error_flag     <= err_q;
    end
  end

endmodule

`default_nettype wire

FILE: src/bve_ctrl.sv
// Controller: sequences each command over decode, read, shift, scan and result load.
`default_nettype none

module bve_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire bve_pkg::dp_stat_t stat,
  output bve_pkg::dp_ctl_t       ctl
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_RD       = 10'b0000000100,
    S_RD_WAIT  = 10'b0000001000,
    S_SH_RD    = 10'b0000010000,
    S_SH_WR    = 10'b0000100000,
    S_INS_WR   = 10'b0001000000,
    S_FIND_RD  = 10'b0010000000,
    S_FIND_CMP = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl            = '0;
    ctl.idx_op     = bve_pkg::IDX_HOLD;
    ctl.wr_sel     = bve_pkg::WR_AT_COUNT;
    ctl.cnt_op     = bve_pkg::CNT_HOLD;
    ctl.latch      = in_valid && in_ready;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.bad) begin
          ctl.err_set = 1'b1;
          state_next  = S_FINISH;
        end else begin
          unique case (stat.cmd) inside
            bve_pkg::CMD_PUSH: begin
              ctl.we     = 1'b1;
              ctl.wr_sel = bve_pkg::WR_AT_COUNT;
              ctl.cnt_op = bve_pkg::CNT_GROW_INC;
              state_next = S_FINISH;
            end
            bve_pkg::CMD_POP: begin
              ctl.idx_op = bve_pkg::IDX_COUNT_M1;
              state_next = S_RD;
            end
            bve_pkg::CMD_INSERT: begin
              if (stat.shift_start) begin
                ctl.idx_op = bve_pkg::IDX_COUNT_M1;
                state_next = S_SH_RD;
              end else begin
                state_next = S_INS_WR;
              end
            end
            bve_pkg::CMD_REMOVE, bve_pkg::CMD_GET: begin
              ctl.idx_op = bve_pkg::IDX_POS;
              state_next = S_RD;
            end
            bve_pkg::CMD_FIND: begin
              ctl.idx_op = bve_pkg::IDX_ZERO;
              state_next = S_FIND_RD;
            end
            bve_pkg::CMD_CLEAR: begin
              ctl.cnt_op = bve_pkg::CNT_CLEAR;
              state_next = S_FINISH;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        ctl.rd_capture = 1'b1;
        state_next     = S_FINISH;
        if (stat.cmd == bve_pkg::CMD_POP) begin
          ctl.cnt_op = bve_pkg::CNT_DEC_SHRINK;
        end else if (stat.cmd == bve_pkg::CMD_REMOVE) begin
          if (stat.shift_start) begin
            ctl.idx_op = bve_pkg::IDX_INC;
            state_next = S_SH_RD;
          end else begin
            ctl.cnt_op = bve_pkg::CNT_DEC_SHRINK;
          end
        end
      end
      S_SH_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        ctl.we = 1'b1;
        if (stat.cmd == bve_pkg::CMD_INSERT) begin
          ctl.wr_sel = bve_pkg::WR_AT_NEXT;
          if (stat.shift_more) begin
            ctl.idx_op = bve_pkg::IDX_DEC;
            state_next = S_SH_RD;
          end else begin
            state_next = S_INS_WR;
          end
        end else begin
          ctl.wr_sel = bve_pkg::WR_AT_PREV;
          if (stat.shift_more) begin
            ctl.idx_op = bve_pkg::IDX_INC;
            state_next = S_SH_RD;
          end else begin
            ctl.cnt_op = bve_pkg::CNT_DEC_SHRINK;
            state_next = S_FINISH;
          end
        end
      end
      S_INS_WR: begin
        ctl.we     = 1'b1;
        ctl.wr_sel = bve_pkg::WR_AT_POS;
        ctl.cnt_op = bve_pkg::CNT_GROW_INC;
        state_next = S_FINISH;
      end
      S_FIND_RD: begin
        if (stat.idx_lt_count) begin
          ctl.rd_en  = 1'b1;
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FIND_CMP: begin
        if (stat.hit) begin
          ctl.match_capture = 1'b1;
          state_next        = S_FINISH;
        end else begin
          ctl.idx_op = bve_pkg::IDX_INC;
          state_next = S_FIND_RD;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/bounded_vector_engine_top.sv
// Top level of the bounded vector engine: controller, datapath and channel wiring.
`default_nettype none

// Channel  Dir  Payload                                                      Handshake
// req      in   cmd[2:0], position[5:0], item_value[31:0] signed             valid/ready
// rsp      out  read_value[31:0], match_index[6:0], item_count[6:0],         valid/ready
//               capacity_level[6:0], error_flag
//
// One command is in work at a time; the element store is a single-port-read,
// single-port-write RAM with registered read. Push, clear, errors and unused
// codes go from decode straight to the result; pop and get read one entry;
// insert and remove shift each moved entry by a read and then a write; find reads
// and compares the entries in turn until a hit or the end of the vector.
// Synchronous active-high reset clears count to 0 and capacity to 1 at once; the
// store itself is not cleared. The finished transaction waits in the output
// register, and a new command is taken while it waits; a command that finishes
// while the previous result is still held stalls in its last step until taken.
module bounded_vector_engine_top #(
  parameter int DEPTH = bve_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = bve_pkg::WIDTH_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  bve_in_if.sink    req,
  bve_out_if.source rsp
);

  bve_pkg::dp_ctl_t  ctl;
  bve_pkg::dp_stat_t stat;
  logic              in_ready;
  logic              out_valid;

  // Sequencer: one-hot state machine, drives the datapath by command struct
  bve_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(rsp.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Store, index walker, count/capacity and result register
  bve_datapath #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (req.cmd),
    .position      (req.position),
    .item_value    (req.item_value),
    .ctl           (ctl),
    .stat          (stat),
    .read_value    (rsp.read_value),
    .match_index   (rsp.match_index),
    .item_count    (rsp.item_count),
    .capacity_level(rsp.capacity_level),
    .error_flag    (rsp.error_flag)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  // Accepting a command moves the controller out of idle, so ready drops right after accept
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("command accepted while the previous one was still in work");

  // Never overwrite a result that has not been taken
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register loaded over a pending result");

  // An erroring command returns no element and no match
  a_error_payload : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.error_flag) |->
      (rsp.read_value == '0) && (rsp.match_index == bve_pkg::MATCH_NONE))
    else $error("error result carries a read value or match index");

endmodule

`default_nettype wire
